// File: sv/md5h_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5h_pkg
// Shared types, constants and round functions of the md5 stream hasher.
// ----------------------------------------------------------------------------
package md5h_pkg;

	localparam logic [31:0] CHAIN_INIT_A = 32'h67452301;
	localparam logic [31:0] CHAIN_INIT_B = 32'hefcdab89;
	localparam logic [31:0] CHAIN_INIT_C = 32'h98badcfe;
	localparam logic [31:0] CHAIN_INIT_D = 32'h10325476;

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
	localparam logic [5:0] FILL_LAST     = 6'd63;
	localparam logic [5:0] FILL_LEN_POS  = 6'd56;
	localparam logic [5:0] ROUND_LAST    = 6'd63;
	localparam logic [1:0] WORD_LAST     = 2'd3;

	localparam logic [31:0] SINE_TABLE [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_TABLE [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_MARK,
		ST_ZERO,
		ST_LENGTH,
		ST_EMIT
	} md5h_state_t;

	typedef enum logic [1:0] {
		PUSH_MSG,
		PUSH_MARK,
		PUSH_ZERO,
		PUSH_LEN
	} md5h_push_src_t;

	typedef struct packed {
		logic           push;
		md5h_push_src_t push_src;
		logic           len_add;
		logic           load;
		logic           round_en;
		logic [5:0]     round_idx;
		logic [5:0]     read_idx;
		logic           fold;
		logic           restart;
		logic [1:0]     word_sel;
	} md5h_cmd_t;

	typedef struct packed {
		logic fill_full;
		logic fill_at_len;
	} md5h_status_t;

	// message word used by a round
	function automatic logic [3:0] msg_index(input logic [5:0] rnd);
		logic [5:0] g;
		begin
			unique case (rnd[5:4])
				2'd0: g = rnd;
				2'd1: g = 6'((7'(rnd) * 7'd5) + 7'd1);
				2'd2: g = 6'((7'(rnd) * 7'd3) + 7'd5);
				default: g = 6'(9'(rnd) * 9'd7);
			endcase
			return g[3:0];
		end
	endfunction

	function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		begin
			unique case (grp)
				2'd0: f = (b & c) | (~b & d);
				2'd1: f = (d & b) | (~d & c);
				2'd2: f = b ^ c ^ d;
				default: f = c ^ (b | ~d);
			endcase
			return f;
		end
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] dbl;
		begin
			dbl = {v, v} << s;
			return dbl[63:32];
		end
	endfunction

endpackage

// File: sv/md5h_msg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5h_msg_if
// Message byte channel: one byte, its valid flag and the end mark per word.
// ----------------------------------------------------------------------------
interface md5h_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       message_end;

	modport source(output valid, output data_byte, output byte_valid, output message_end,
		input ready);
	modport sink(input valid, input data_byte, input byte_valid, input message_end,
		output ready);
endinterface

// File: sv/md5h_digest_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5h_digest_if
// Digest channel: one chaining word of the final digest per word.
// ----------------------------------------------------------------------------
interface md5h_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source(output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink(input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

// File: sv/md5h_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5h_ctrl
// Sequencer: byte intake, round count, padding steps and digest readout.
// ----------------------------------------------------------------------------
module md5h_ctrl
	import md5h_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         msg_valid,
	input  logic         msg_byte_valid,
	input  logic         msg_end,
	output logic         msg_ready,
	output logic         dig_valid,
	input  logic         dig_ready,
	input  md5h_status_t status,
	output md5h_cmd_t    cmd
);

	md5h_state_t state_q, state_d;
	md5h_state_t ret_q, ret_d;
	logic [5:0]  rnd_q, rnd_d;
	logic [1:0]  word_q, word_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			rnd_q   <= '0;
			word_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			rnd_q   <= rnd_d;
			word_q  <= word_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		rnd_d     = rnd_q;
		word_d    = word_q;
		cmd       = '0;
		msg_ready = 1'b0;
		dig_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				msg_ready = 1'b1;
				if (msg_valid) begin
					if (msg_byte_valid) begin
						cmd.push     = 1'b1;
						cmd.push_src = PUSH_MSG;
						cmd.len_add  = 1'b1;
					end
					if (msg_byte_valid && status.fill_full) begin
						state_d = ST_LOAD;
						ret_d   = msg_end ? ST_MARK : ST_IDLE;
					end else if (msg_end) begin
						state_d = ST_MARK;
					end
				end
			end
			ST_LOAD: begin
				cmd.load     = 1'b1;
				cmd.read_idx = '0;
				rnd_d        = '0;
				state_d      = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_en  = 1'b1;
				cmd.round_idx = rnd_q;
				cmd.read_idx  = rnd_q + 6'd1;
				rnd_d         = rnd_q + 6'd1;
				if (rnd_q == ROUND_LAST) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ret_q;
			end
			ST_MARK: begin
				cmd.push     = 1'b1;
				cmd.push_src = PUSH_MARK;
				state_d      = ST_ZERO;
				if (status.fill_full) begin
					state_d = ST_LOAD;
					ret_d   = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (status.fill_at_len) begin
					state_d = ST_LENGTH;
				end else begin
					cmd.push     = 1'b1;
					cmd.push_src = PUSH_ZERO;
					if (status.fill_full) begin
						state_d = ST_LOAD;
						ret_d   = ST_ZERO;
					end
				end
			end
			ST_LENGTH: begin
				cmd.push     = 1'b1;
				cmd.push_src = PUSH_LEN;
				if (status.fill_full) begin
					state_d = ST_LOAD;
					ret_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				dig_valid    = 1'b1;
				cmd.word_sel = word_q;
				if (dig_ready) begin
					word_d = word_q + 2'd1;
					if (word_q == WORD_LAST) begin
						cmd.restart = 1'b1;
						state_d     = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/md5h_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5h_datapath
// Block buffer, fill count, bit length, chaining words and the round unit.
// ----------------------------------------------------------------------------
module md5h_datapath
	import md5h_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  md5h_cmd_t    cmd,
	input  logic [7:0]   data_byte,
	output md5h_status_t status,
	output logic [31:0]  digest_word
);

	logic [3:0][7:0] buf_q [16];
	logic [31:0]     msg_word_q;
	logic [5:0]      fill_q;
	logic [63:0]     bit_len_q;
	logic [31:0]     chain_q [4];
	logic [31:0]     a_q, b_q, c_q, d_q;
	logic [7:0]      wr_byte;
	logic [31:0]     sum;
	logic [31:0]     f_val;
	logic [4:0]      shift;

	always_comb begin
		unique case (cmd.push_src)
			PUSH_MSG:  wr_byte = data_byte;
			PUSH_MARK: wr_byte = PAD_MARK_BYTE;
			PUSH_ZERO: wr_byte = '0;
			default:   wr_byte = bit_len_q[{fill_q[2:0], 3'b000} +: 8];
		endcase
	end

	assign status.fill_full   = (fill_q == FILL_LAST);
	assign status.fill_at_len = (fill_q == FILL_LEN_POS);

	// block buffer, byte lanes of little-endian message words
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			buf_q[fill_q[5:2]][fill_q[1:0]] <= wr_byte;
		end
		msg_word_q <= buf_q[msg_index(cmd.read_idx)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			bit_len_q <= '0;
		end else if (cmd.restart) begin
			fill_q    <= '0;
			bit_len_q <= '0;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.len_add) begin
				bit_len_q <= bit_len_q + 64'd8;
			end
		end
	end

	assign f_val = round_f(cmd.round_idx[5:4], b_q, c_q, d_q);
	assign sum   = a_q + f_val + SINE_TABLE[cmd.round_idx] + msg_word_q;
	assign shift = ROT_TABLE[{cmd.round_idx[5:4], cmd.round_idx[1:0]}];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (cmd.round_en) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rotl(sum, shift);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= CHAIN_INIT_A;
			chain_q[1] <= CHAIN_INIT_B;
			chain_q[2] <= CHAIN_INIT_C;
			chain_q[3] <= CHAIN_INIT_D;
		end else if (cmd.restart) begin
			chain_q[0] <= CHAIN_INIT_A;
			chain_q[1] <= CHAIN_INIT_B;
			chain_q[2] <= CHAIN_INIT_C;
			chain_q[3] <= CHAIN_INIT_D;
		end else if (cmd.fold) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
		end
	end

	assign digest_word = chain_q[cmd.word_sel];

endmodule

// File: sv/md5_stream_hasher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_stream_hasher_unit
// MD5 digest over a byte stream, one round per clock on a shared round unit.
// ----------------------------------------------------------------------------
//
// channel  direction  payload
// msg      in         data_byte[7:0], byte_valid, message_end
// digest   out        digest_word[31:0], word_index[1:0], last_word
//
// a message byte is taken while msg ready is high; the 64th byte of a block is
// followed by a load, 64 rounds on the single round unit and a fold, and no
// further byte is taken until that block is through
// an end word adds the padding bytes (9 to 72), a pause at the length slot,
// and a load, 64 rounds and a fold for each block it completes, then four digest
// words, one per accepted word
// msg ready is high only while no byte, block, padding or digest is in progress
// a stalled digest word holds until taken; reset needs no clearing pass
//
module md5_stream_hasher_unit
	import md5h_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	md5h_msg_if.sink     msg,
	md5h_digest_if.source digest
);

	md5h_cmd_t    cmd;
	md5h_status_t status;
	logic [31:0]  chain_word;

	// sequencer: intake, rounds, padding and readout
	md5h_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg.valid),
		.msg_byte_valid (msg.byte_valid),
		.msg_end        (msg.message_end),
		.msg_ready      (msg.ready),
		.dig_valid      (digest.valid),
		.dig_ready      (digest.ready),
		.status         (status),
		.cmd            (cmd)
	);

	// storage and arithmetic
	md5h_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (msg.data_byte),
		.status      (status),
		.digest_word (chain_word)
	);

	// digest words come straight from the chaining registers
	assign digest.digest_word = chain_word;
	assign digest.word_index  = cmd.word_sel;
	assign digest.last_word   = (cmd.word_sel == WORD_LAST);

endmodule

// File: sv/md5h_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5h_checker
// Port-level checks of the md5 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module md5h_checker
	import md5h_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        msg_ready,
	input logic        dig_valid,
	input logic        dig_ready,
	input logic [31:0] dig_word,
	input logic [1:0]  dig_index,
	input logic        dig_last
);

	// a stalled digest word holds
	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(dig_word) && $stable(dig_index))
		else $error("digest word changed while stalled");

	// words of one digest come in order
	a_dig_order: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && !dig_last |=>
		dig_valid && dig_index == $past(dig_index) + 2'd1)
		else $error("digest words out of order");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> dig_last == (dig_index == WORD_LAST))
		else $error("last word flag wrong");

	// no intake while a digest is being read out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> !msg_ready)
		else $error("input taken during readout");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && dig_last |=> msg_ready && !dig_valid)
		else $error("not ready after digest");

endmodule

bind md5_stream_hasher_unit md5h_checker u_md5h_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_ready (msg.ready),
	.dig_valid (digest.valid),
	.dig_ready (digest.ready),
	.dig_word  (digest.digest_word),
	.dig_index (digest.word_index),
	.dig_last  (digest.last_word)
);
